### hdl/rpsc_pkg.sv
// ----------------------------------------------------------------------------
// rpsc_pkg
// Shared types and constants for the RO pump safety controller.
// ----------------------------------------------------------------------------
package rpsc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned RETRY_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [RETRY_W-1:0] RETRY_SAT = '1;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0]  DRY_LIMIT_RST   = TIME_W'(30000);
    localparam logic [TIME_W-1:0]  RETRY_WAIT_RST  = TIME_W'(60000);
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = RETRY_W'(3);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ENABLE = 2'd1,
        CMD_MANUAL = 2'd2,
        CMD_RELAY  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RT_IDLE   = 2'd0,
        RT_PURIFY = 2'd1,
        RT_WAIT   = 2'd2,
        RT_LOCKED = 2'd3
    } routine_t;

    typedef enum logic [1:0] {
        FC_NONE = 2'd0,
        FC_LEAK = 2'd1,
        FC_DRY  = 2'd2
    } fault_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCENARIO_B  = 3'd0,
        CFG_SOLAR       = 3'd1,
        CFG_DRY_LIMIT   = 3'd2,
        CFG_RETRY_WAIT  = 3'd3,
        CFG_MAX_RETRIES = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic               scenario_b;
        logic               solar_permits;
        logic [TIME_W-1:0]  dry_run_limit_ms;
        logic [TIME_W-1:0]  retry_wait_ms;
        logic [RETRY_W-1:0] max_retries;
    } cfg_t;

    typedef struct packed {
        cmd_t              command;
        logic              arg;
        logic [TIME_W-1:0] now_ms;
        logic              leak;
        logic              tank_full;
        logic              pressure_ok;
    } item_t;

    typedef struct packed {
        routine_t           routine;
        fault_t             fault;
        logic               lock_flag;
        logic [TIME_W-1:0]  low_since_ms;
        logic               low_timing;
        logic [RETRY_W-1:0] retries;
        logic [TIME_W-1:0]  wait_until_ms;
        logic               in_wait;
        logic               manual_request;
        logic               auto_mode;
        logic               enabled;
        logic               pump_state;
        logic               relay1_state;
    } ctl_state_t;

    localparam ctl_state_t CTL_STATE_RST = '{
        routine:        RT_IDLE,
        fault:          FC_NONE,
        lock_flag:      1'b0,
        low_since_ms:   '0,
        low_timing:     1'b0,
        retries:        '0,
        wait_until_ms:  '0,
        in_wait:        1'b0,
        manual_request: 1'b0,
        auto_mode:      1'b1,
        enabled:        1'b1,
        pump_state:     1'b0,
        relay1_state:   1'b0
    };

endpackage

### hdl/rpsc_if.sv
// ----------------------------------------------------------------------------
// rpsc_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface rpsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic        arg;
    logic [31:0] now_ms;
    logic        leak;
    logic        tank_full;
    logic        pressure_ok;

    modport source (
        output valid, command, arg, now_ms, leak, tank_full, pressure_ok,
        input  ready
    );
    modport sink (
        input  valid, command, arg, now_ms, leak, tank_full, pressure_ok,
        output ready
    );
endinterface

interface rpsc_out_if;
    logic       valid;
    logic       ready;
    logic       pump_on;
    logic       inlet_relay_on;
    logic [1:0] routine;
    logic [1:0] fault_code;
    logic       is_locked;
    logic [7:0] retry_count;
    logic       is_enabled;

    modport source (
        output valid, pump_on, inlet_relay_on, routine, fault_code, is_locked,
               retry_count, is_enabled,
        input  ready
    );
    modport sink (
        input  valid, pump_on, inlet_relay_on, routine, fault_code, is_locked,
               retry_count, is_enabled,
        output ready
    );
endinterface

### hdl/rpsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rpsc_cfg_regs
// Write-only configuration register bank.
// ----------------------------------------------------------------------------
module rpsc_cfg_regs
    import rpsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SCENARIO_B:  cfg_next.scenario_b       = cfg_data[0];
                CFG_SOLAR:       cfg_next.solar_permits    = cfg_data[0];
                CFG_DRY_LIMIT:   cfg_next.dry_run_limit_ms = cfg_data[TIME_W-1:0];
                CFG_RETRY_WAIT:  cfg_next.retry_wait_ms    = cfg_data[TIME_W-1:0];
                CFG_MAX_RETRIES: cfg_next.max_retries      = cfg_data[RETRY_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scenario_b       <= 1'b0;
            cfg_reg.solar_permits    <= 1'b1;
            cfg_reg.dry_run_limit_ms <= DRY_LIMIT_RST;
            cfg_reg.retry_wait_ms    <= RETRY_WAIT_RST;
            cfg_reg.max_retries      <= MAX_RETRIES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/rpsc_step.sv
// ----------------------------------------------------------------------------
// rpsc_step
// Next-state logic: applies one command item to the controller state.
// ----------------------------------------------------------------------------
module rpsc_step
    import rpsc_pkg::*;
(
    input  cfg_t       cfg,
    input  item_t      item,
    input  ctl_state_t cur,
    output ctl_state_t nxt
);

    logic               safe_relay;   // relay1 level for a safe shutdown
    logic               wait_hold;
    logic               interlock;
    logic               want;
    logic [TIME_W-1:0]  low_elapsed;
    logic               dry_expired;
    logic [RETRY_W-1:0] retries_inc;

    assign safe_relay  = ~cfg.scenario_b;
    assign wait_hold   = cur.in_wait && (item.now_ms < cur.wait_until_ms);
    assign interlock   = cfg.scenario_b && cur.relay1_state;
    assign want        = (cur.auto_mode || cur.manual_request) && !item.tank_full &&
                         item.pressure_ok && cfg.solar_permits && !interlock;
    assign low_elapsed = item.now_ms - cur.low_since_ms;
    assign dry_expired = low_elapsed >= cfg.dry_run_limit_ms;
    assign retries_inc = (cur.retries == RETRY_SAT) ? cur.retries
                                                    : cur.retries + RETRY_W'(1);

    always_comb
    begin
        nxt = cur;
        case (item.command)
            CMD_TICK:
            begin
                if (item.leak)
                begin
                    // Leak: latch lock, shut down safely
                    nxt.pump_state   = 1'b0;
                    nxt.relay1_state = safe_relay;
                    if (!cur.lock_flag || cur.fault != FC_LEAK)
                    begin
                        nxt.fault     = FC_LEAK;
                        nxt.lock_flag = 1'b1;
                        nxt.routine   = RT_LOCKED;
                    end
                end
                else if (cur.lock_flag)
                begin
                    nxt.pump_state = 1'b0;
                end
                else if (!cur.enabled)
                begin
                    nxt.pump_state   = 1'b0;
                    nxt.relay1_state = safe_relay;
                    nxt.routine      = RT_IDLE;
                    nxt.low_timing   = 1'b0;
                end
                else if (wait_hold)
                begin
                    // Still inside the retry wait window
                    nxt.routine    = RT_WAIT;
                    nxt.pump_state = 1'b0;
                end
                else
                begin
                    nxt.in_wait = 1'b0;
                    if (cur.in_wait || interlock)
                    begin
                        nxt.pump_state = 1'b0;
                    end
                    // Stop on tank full, interlock or solar veto
                    if (nxt.pump_state &&
                        (item.tank_full || interlock || !cfg.solar_permits))
                    begin
                        nxt.pump_state = 1'b0;
                        nxt.low_timing = 1'b0;
                    end
                    if (want)
                    begin
                        nxt.pump_state = 1'b1;
                    end
                    nxt.routine = nxt.pump_state ? RT_PURIFY : RT_IDLE;

                    // Dry-run timing on low pressure
                    if (nxt.pump_state && !item.pressure_ok)
                    begin
                        if (!nxt.low_timing)
                        begin
                            nxt.low_timing   = 1'b1;
                            nxt.low_since_ms = item.now_ms;
                        end
                        else if (dry_expired)
                        begin
                            nxt.pump_state = 1'b0;
                            nxt.retries    = retries_inc;
                            nxt.low_timing = 1'b0;
                            if (retries_inc >= cfg.max_retries)
                            begin
                                nxt.fault        = FC_DRY;
                                nxt.lock_flag    = 1'b1;
                                nxt.routine      = RT_LOCKED;
                                nxt.relay1_state = safe_relay;
                            end
                            else
                            begin
                                nxt.in_wait       = 1'b1;
                                nxt.wait_until_ms = item.now_ms + cfg.retry_wait_ms;
                                nxt.routine       = RT_WAIT;
                                nxt.relay1_state  = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        nxt.low_timing = 1'b0;
                        if (nxt.pump_state && item.pressure_ok)
                        begin
                            nxt.retries = '0;
                        end
                    end
                end
            end

            CMD_ENABLE:
            begin
                if (!(cur.lock_flag && item.arg))
                begin
                    nxt.enabled = item.arg;
                    if (!item.arg)
                    begin
                        nxt.pump_state   = 1'b0;
                        nxt.relay1_state = safe_relay;
                        nxt.low_timing   = 1'b0;
                        nxt.in_wait      = 1'b0;
                        nxt.routine      = RT_IDLE;
                    end
                    else
                    begin
                        nxt.auto_mode = 1'b1;
                        if (!cfg.scenario_b)
                        begin
                            nxt.relay1_state = 1'b0;
                        end
                    end
                end
            end

            CMD_MANUAL:
            begin
                if (!cur.lock_flag && cur.enabled)
                begin
                    nxt.manual_request = item.arg;
                    nxt.auto_mode      = 1'b0;
                    if (!item.arg)
                    begin
                        nxt.pump_state = 1'b0;
                    end
                end
            end

            CMD_RELAY:
            begin
                if (!cur.lock_flag && cur.enabled)
                begin
                    if (cfg.scenario_b && item.arg)
                    begin
                        nxt.pump_state = 1'b0;
                    end
                    nxt.relay1_state = item.arg;
                end
            end

            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### hdl/ro_pump_safety_controller.sv
// ----------------------------------------------------------------------------
// ro_pump_safety_controller
// Pump and inlet relay safety controller with leak lock and dry-run retries.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_in carries command items (tick with time and sensor bits, master
//   enable, manual purify request, inlet relay request). res_out returns one
//   result item per command: relay levels, routine, fault code, lock flag,
//   retry count and enable state, all taken after the command is applied.
//   The cfg_we/cfg_index/cfg_data port writes the five setup registers; write
//   them only while no items are in flight.
// Timing:
//   An item is registered in the input register, then its result is loaded
//   into the output register, which drives res_out.valid. One item per cycle
//   is accepted in steady state while res_out is taken; the state update is
//   a single pass of flag logic, one subtract, compares and two adds.
// Reset:
//   rst_n clears the controller to idle, unlocked, enabled, auto mode, pump
//   and relay off, and loads the register defaults.
// Stall:
//   If res_out is not taken, the output register holds its item and the
//   input register fills; cmd_in.ready drops once both are occupied.
// ----------------------------------------------------------------------------
module ro_pump_safety_controller
    import rpsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rpsc_in_if.sink              cmd_in,
    rpsc_out_if.source           res_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t       cfg;
    item_t      in_item;
    ctl_state_t state_reg;
    ctl_state_t state_next;

    logic       s1_valid_reg;
    item_t      s1_item_reg;
    logic       out_valid_reg;
    ctl_state_t out_reg;

    logic       out_free;
    logic       advance;
    logic       in_take;

    // Configuration registers
    rpsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake control
    assign out_free     = !out_valid_reg || res_out.ready;
    assign advance      = s1_valid_reg && out_free;
    assign cmd_in.ready = !s1_valid_reg || advance;
    assign in_take      = cmd_in.valid && cmd_in.ready;

    assign in_item.command     = cmd_t'(cmd_in.command);
    assign in_item.arg         = cmd_in.arg;
    assign in_item.now_ms      = cmd_in.now_ms;
    assign in_item.leak        = cmd_in.leak;
    assign in_item.tank_full   = cmd_in.tank_full;
    assign in_item.pressure_ok = cmd_in.pressure_ok;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_in.ready)
        begin
            s1_valid_reg <= cmd_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
    end

    // Next-state logic
    rpsc_step u_step (
        .cfg  (cfg),
        .item (s1_item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // Controller state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_STATE_RST;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= state_next;
        end
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.pump_on        = out_reg.pump_state;
    assign res_out.inlet_relay_on = out_reg.relay1_state;
    assign res_out.routine        = out_reg.routine;
    assign res_out.fault_code     = out_reg.fault;
    assign res_out.is_locked      = out_reg.lock_flag;
    assign res_out.retry_count    = out_reg.retries;
    assign res_out.is_enabled     = out_reg.enabled;

endmodule
